// File: hdl/lba_pkg.sv
// Shared types and constants for the linked block allocator.
// Holds field widths, status codes and the controller/datapath interface structs.
// No dependencies.
`default_nettype none

package lba_pkg;

  // Fixed field widths
  localparam int START_W  = 10;
  localparam int COUNT_W  = 7;
  localparam int INDEX_W  = 10;
  localparam int FILE_W   = 7;
  localparam int STATUS_W = 3;
  localparam int OWNER_W  = 8;
  localparam int CFG_W    = 11;

  // Owner map code for a free block
  localparam logic [OWNER_W-1:0] FREE_CODE = 8'hFF;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_START   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_COUNT   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TABLE_FULL  = 3'd4;

  // Reset value of the managed disk size
  localparam logic [CFG_W-1:0] SIZE_RESET = 11'd1024;

  // Commands from controller to datapath
  typedef struct packed {
    logic clr;          // clear one owner map entry
    logic accept;       // latch request, read owner of start block
    logic check;        // evaluate request checks, seed the chain
    logic scan;         // one step of the free block scan
    logic set_nospace;  // record a failed scan
    logic cand_rd;      // read the next chain entry
    logic load_out;     // present a chain result, claim its block
    logic load_err;     // present the error result
  } lba_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic                clr_done;
    logic [STATUS_W-1:0] chk_code;
    logic                single;
    logic                scan_hit_last;
    logic                scan_exhausted;
    logic                emit_last;
    logic                out_free;
  } lba_sts_t;

endpackage

`default_nettype wire

// File: hdl/linked_block_allocator.sv
// Linked block allocator: after reset a clearing pass marks every block free;
// no request is taken during it. One request is in work at a time.
// Each request is latched and checked; unless it asks for one block, a scan
// makes one owner map read per cycle; then each chain result is read and loaded.
// An error result is loaded once the output register is free.
// Reset: synchronous, active high; size register returns to 1024.
`default_nettype none

module linked_block_allocator #(
  parameter int DISK_BLOCKS     = 1024,
  parameter int MAX_FILES       = 128,
  parameter int MAX_FILE_BLOCKS = 64
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           cfg_wr_en,
  input  wire  [lba_pkg::CFG_W-1:0]     cfg_wr_data,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire  [lba_pkg::START_W-1:0]   first_block,
  input  wire  [lba_pkg::COUNT_W-1:0]   block_count,
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic [lba_pkg::INDEX_W-1:0]   block_index,
  output logic [lba_pkg::FILE_W-1:0]    file_id,
  output logic [lba_pkg::STATUS_W-1:0]  status,
  output logic                          last
);

  lba_pkg::lba_cmd_t cmd;
  lba_pkg::lba_sts_t sts;

  // Sequencing
  lba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Storage and arithmetic
  lba_datapath #(
    .DISK_BLOCKS     (DISK_BLOCKS),
    .MAX_FILES       (MAX_FILES),
    .MAX_FILE_BLOCKS (MAX_FILE_BLOCKS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .first_block (first_block),
    .block_count (block_count),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .block_index (block_index),
    .file_id     (file_id),
    .status      (status),
    .last        (last),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

`default_nettype wire

// File: hdl/lba_ctrl.sv
// Controller state machine for the linked block allocator.
// Sequences clearing, request checks, the scan and result emission.
// Depends on lba_pkg.
`default_nettype none

module lba_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire lba_pkg::lba_sts_t sts,
  output lba_pkg::lba_cmd_t   cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_CRD   = 3'd4;
  localparam logic [2:0] S_CLD   = 3'd5;
  localparam logic [2:0] S_ERR   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  // Take a new request only when idle
  assign in_stall = (state != S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        if (sts.clr_done) begin
          state_next = S_IDLE;
        end else begin
          cmd.clr = 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (sts.chk_code != lba_pkg::ST_OK) begin
          state_next = S_ERR;
        end else if (sts.single) begin
          state_next = S_CRD;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_hit_last) begin
          state_next = S_CRD;
        end else if (sts.scan_exhausted) begin
          cmd.set_nospace = 1'b1;
          state_next      = S_ERR;
        end
      end
      S_CRD: begin
        cmd.cand_rd = 1'b1;
        state_next  = S_CLD;
      end
      S_CLD: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = sts.emit_last ? S_IDLE : S_CRD;
        end
      end
      S_ERR: begin
        if (sts.out_free) begin
          cmd.load_err = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// File: hdl/lba_datapath.sv
// Datapath of the linked block allocator: owner map and chain memories,
// scan and emit counters, size register, file counter and output register.
// Depends on lba_pkg.
`default_nettype none

module lba_datapath #(
  parameter int DISK_BLOCKS     = 1024,
  parameter int MAX_FILES       = 128,
  parameter int MAX_FILE_BLOCKS = 64
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               cfg_wr_en,
  input  wire  [lba_pkg::CFG_W-1:0]         cfg_wr_data,
  input  wire  [lba_pkg::START_W-1:0]       first_block,
  input  wire  [lba_pkg::COUNT_W-1:0]       block_count,
  input  wire                               out_stall,
  output logic                              out_valid,
  output logic [lba_pkg::INDEX_W-1:0]       block_index,
  output logic [lba_pkg::FILE_W-1:0]        file_id,
  output logic [lba_pkg::STATUS_W-1:0]      status,
  output logic                              last,
  input  wire lba_pkg::lba_cmd_t            cmd,
  output lba_pkg::lba_sts_t                 sts
);

  localparam int AW   = (DISK_BLOCKS > 1) ? $clog2(DISK_BLOCKS) : 1;
  localparam int CMPW = AW + lba_pkg::CFG_W;
  localparam int KW   = (MAX_FILE_BLOCKS > 1) ? $clog2(MAX_FILE_BLOCKS) : 1;

  localparam logic [CMPW-1:0]              DISK_CMP  = CMPW'(DISK_BLOCKS);
  localparam logic [AW:0]                  CLR_END   = (AW + 1)'(DISK_BLOCKS);
  localparam logic [lba_pkg::COUNT_W-1:0]  CNT_MAX   = lba_pkg::COUNT_W'(MAX_FILE_BLOCKS);
  localparam logic [lba_pkg::OWNER_W-1:0]  FILES_MAX = lba_pkg::OWNER_W'(MAX_FILES);

  // Memories
  logic [lba_pkg::OWNER_W-1:0] owner_mem [DISK_BLOCKS];
  logic [AW-1:0]               cand_mem  [MAX_FILE_BLOCKS];

  // Registers
  logic [lba_pkg::CFG_W-1:0]    disk_size_in_use;
  logic [lba_pkg::START_W-1:0]  req_start;
  logic [lba_pkg::COUNT_W-1:0]  req_count;
  logic [lba_pkg::OWNER_W-1:0]  owner_rd;
  logic [AW-1:0]                cand_rd;
  logic [AW:0]                  clr_addr;
  logic [CMPW-1:0]              scan_b;
  logic                         rd_pend;
  logic [AW-1:0]                rd_addr;
  logic [lba_pkg::COUNT_W-1:0]  found;
  logic [lba_pkg::COUNT_W-1:0]  emit_k;
  logic [lba_pkg::OWNER_W-1:0]  files_allocated;
  logic [lba_pkg::STATUS_W-1:0] err_code;

  // Combinational helpers
  logic [CMPW-1:0]               disk_ext;
  logic [CMPW-1:0]               size_cap;
  logic [CMPW-1:0]               in_start_cmp;
  logic [CMPW-1:0]               req_start_cmp;
  logic [AW-1:0]                 req_start_addr;
  logic                          scan_issue;
  logic                          scan_hit;
  logic                          owner_we;
  logic [AW-1:0]                 owner_waddr;
  logic [lba_pkg::OWNER_W-1:0]   owner_wdata;
  logic                          owner_re;
  logic [AW-1:0]                 owner_raddr;
  logic                          cand_we;
  logic [KW-1:0]                 cand_waddr;
  logic [AW-1:0]                 cand_wdata;
  logic [AW+lba_pkg::INDEX_W-1:0] blk_ext;
  logic [lba_pkg::STATUS_W-1:0]  chk_code;

  // Managed size, capped at the disk size
  assign disk_ext       = {{AW{1'b0}}, disk_size_in_use};
  assign size_cap       = (disk_ext > DISK_CMP) ? DISK_CMP : disk_ext;
  assign in_start_cmp   = {{(AW + 1){1'b0}}, first_block};
  assign req_start_cmp  = {{(AW + 1){1'b0}}, req_start};
  assign req_start_addr = req_start_cmp[AW-1:0];

  // Request checks, in priority order
  always_comb begin
    if (req_count == '0 || req_count > CNT_MAX) begin
      chk_code = lba_pkg::ST_BAD_COUNT;
    end else if (files_allocated >= FILES_MAX) begin
      chk_code = lba_pkg::ST_TABLE_FULL;
    end else if (req_start_cmp >= size_cap || owner_rd != lba_pkg::FREE_CODE) begin
      chk_code = lba_pkg::ST_BAD_START;
    end else begin
      chk_code = lba_pkg::ST_OK;
    end
  end

  // Scan: issue one read a cycle, qualify the block read last cycle
  assign scan_issue = cmd.scan && (scan_b < size_cap);
  assign scan_hit   = cmd.scan && rd_pend && (rd_addr != req_start_addr) &&
                      (owner_rd == lba_pkg::FREE_CODE) && (found < req_count);

  // Owner map port selection
  always_comb begin
    owner_we    = 1'b0;
    owner_waddr = clr_addr[AW-1:0];
    owner_wdata = lba_pkg::FREE_CODE;
    if (cmd.clr) begin
      owner_we = 1'b1;
    end else if (cmd.load_out) begin
      owner_we    = 1'b1;
      owner_waddr = cand_rd;
      owner_wdata = files_allocated;
    end
    owner_re    = cmd.accept || scan_issue;
    owner_raddr = cmd.accept ? in_start_cmp[AW-1:0] : scan_b[AW-1:0];
  end

  // Chain list port selection
  always_comb begin
    cand_we    = 1'b0;
    cand_waddr = found[KW-1:0];
    cand_wdata = rd_addr;
    if (cmd.check) begin
      cand_we    = 1'b1;
      cand_waddr = '0;
      cand_wdata = req_start_addr;
    end else if (scan_hit) begin
      cand_we = 1'b1;
    end
  end

  // Owner map memory
  always_ff @(posedge clk) begin
    if (owner_we) begin
      owner_mem[owner_waddr] <= owner_wdata;
    end
    if (owner_re) begin
      owner_rd <= owner_mem[owner_raddr];
    end
  end

  // Chain list memory
  always_ff @(posedge clk) begin
    if (cand_we) begin
      cand_mem[cand_waddr] <= cand_wdata;
    end
    if (cmd.cand_rd) begin
      cand_rd <= cand_mem[emit_k[KW-1:0]];
    end
  end

  // Request latch and scan bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_start <= first_block;
      req_count <= block_count;
    end
    if (cmd.scan) begin
      rd_addr <= scan_b[AW-1:0];
    end
  end

  // Control counters and registers
  always_ff @(posedge clk) begin
    if (rst) begin
      disk_size_in_use <= lba_pkg::SIZE_RESET;
      clr_addr         <= '0;
      scan_b           <= '0;
      rd_pend          <= 1'b0;
      found            <= '0;
      emit_k           <= '0;
      files_allocated  <= '0;
      err_code         <= lba_pkg::ST_OK;
    end else begin
      if (cfg_wr_en) begin
        disk_size_in_use <= cfg_wr_data;
      end
      if (cmd.clr) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.check) begin
        err_code <= chk_code;
        scan_b   <= '0;
        rd_pend  <= 1'b0;
        found    <= lba_pkg::COUNT_W'(1);
        emit_k   <= '0;
      end
      if (cmd.scan) begin
        rd_pend <= scan_issue;
        if (scan_issue) begin
          scan_b <= scan_b + 1'b1;
        end
        if (scan_hit) begin
          found <= found + 1'b1;
        end
      end
      if (cmd.set_nospace) begin
        err_code <= lba_pkg::ST_NO_SPACE;
      end
      if (cmd.load_out) begin
        emit_k <= emit_k + 1'b1;
        if (sts.emit_last) begin
          files_allocated <= files_allocated + 1'b1;
        end
      end
    end
  end

  // Output register
  assign blk_ext = {{lba_pkg::INDEX_W{1'b0}}, cand_rd};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out || cmd.load_err) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      block_index <= blk_ext[lba_pkg::INDEX_W-1:0];
      file_id     <= files_allocated[lba_pkg::FILE_W-1:0];
      status      <= lba_pkg::ST_OK;
      last        <= sts.emit_last;
    end else if (cmd.load_err) begin
      block_index <= '0;
      file_id     <= '0;
      status      <= err_code;
      last        <= 1'b1;
    end
  end

  // Status to controller
  always_comb begin
    sts.clr_done       = (clr_addr == CLR_END);
    sts.chk_code       = chk_code;
    sts.single         = (req_count == lba_pkg::COUNT_W'(1));
    sts.scan_hit_last  = scan_hit && ((found + 1'b1) == req_count);
    sts.scan_exhausted = cmd.scan && !rd_pend && (scan_b >= size_cap);
    sts.emit_last      = ((emit_k + 1'b1) == req_count);
    sts.out_free       = !out_valid || !out_stall;
  end

endmodule

`default_nettype wire
